// ----- src/gpnmp_pkg.sv -----
// Shared types and constants for the GCN post-norm mean pooling block.
// No dependencies; used by gpnmp_div, gpnmp_mul and gcn_post_norm_mean_pool.
package gpnmp_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DEGREE_W   = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned DIMIDX_W   = 7;
  localparam int unsigned STEP_W     = 6;

  localparam int unsigned IN_TDATA_W  = 240;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 8;

  localparam int unsigned OFS_MESSAGE = 0;
  localparam int unsigned OFS_FEATURE = 32;
  localparam int unsigned OFS_DEGREE  = 64;
  localparam int unsigned OFS_ROOT    = 74;
  localparam int unsigned OFS_MEAN    = 106;
  localparam int unsigned OFS_SQRTVAR = 138;
  localparam int unsigned OFS_SCALE   = 170;
  localparam int unsigned OFS_SHIFT   = 202;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// ----- src/gpnmp_div.sv -----
// Bit-serial restoring divider, unsigned, one quotient bit per cycle.
// Depends on gpnmp_pkg (div_req_t, WORD_W, STEP_W).
module gpnmp_div #(
  parameter int unsigned DW = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gpnmp_pkg::div_req_t        req_i,
  input  logic [DW-1:0]              dividend_i,
  input  logic [gpnmp_pkg::WORD_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [DW-1:0]              quotient_o
);

  localparam int unsigned W = gpnmp_pkg::WORD_W;

  logic                         busy_q;
  logic                         done_q;
  logic [gpnmp_pkg::STEP_W-1:0] cnt_q;
  logic [W-1:0]                 rem_q;
  logic [W-1:0]                 dsr_q;
  logic [DW-1:0]                dd_q;

  logic [W:0]   rem_sh;
  logic [W+1:0] trial;
  logic         ge;

  assign rem_sh = {rem_q, dd_q[DW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign ge     = ~trial[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - gpnmp_pkg::STEP_W'(1);
        if (cnt_q == gpnmp_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dd_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[W-1:0] : rem_sh[W-1:0];
      dd_q  <= {dd_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dd_q;

endmodule

// ----- src/gpnmp_mul.sv -----
// Bit-serial signed 32x32 multiplier, one multiplier bit per cycle.
// Depends on gpnmp_pkg (WORD_W).
module gpnmp_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [gpnmp_pkg::WORD_W-1:0]   a_i,
  input  logic [gpnmp_pkg::WORD_W-1:0]   b_i,
  output logic                           done_o,
  output logic [2*gpnmp_pkg::WORD_W-1:0] product_o
);

  localparam int unsigned W = gpnmp_pkg::WORD_W;

  logic                 busy_q;
  logic                 done_q;
  logic [4:0]           cnt_q;
  logic [W:0]           hi_q;
  logic [W-1:0]         lo_q;
  logic [W-1:0]         a_q;

  logic [W+1:0] a_ext;
  logic [W+1:0] addend;
  logic [W+1:0] sum;
  logic         last;

  assign last   = (cnt_q == 5'd31);
  assign a_ext  = {{2{a_q[W-1]}}, a_q};
  assign addend = lo_q[0] ? (last ? (~a_ext + (W+2)'(1)) : a_ext) : '0;
  assign sum    = {hi_q[W], hi_q} + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      a_q  <= a_i;
    end else if (busy_q) begin
      hi_q <= sum[W+1:1];
      lo_q <= {sum[0], lo_q[W-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q[W-1:0], lo_q};

endmodule

// ----- src/gcn_post_norm_mean_pool.sv -----
// GCN readout: per-node update, batch norm and global mean pooling per dimension.
// Depends on gpnmp_pkg, gpnmp_div and gpnmp_mul.
//
// Usage: items enter on the s_axis channel one at a time, dimension-major,
// node_count items per dimension (at most MAX_NODES, one when it is zero).
// Each item runs on a shared bit-serial divider and a bit-serial multiplier:
// an accept step, the degree divide, the variance divide (skipped when
// sqrt_var is zero), the scale multiply and an accumulate step.
// s_axis_tready is high only while no item is in progress. On the last node of
// a dimension a mean divide (skipped when the count is zero) and an output
// step follow; tlast marks the final dimension, tuser carries the dimension
// index and the divide-by-zero flag.
// The output register holds a result until taken; the next item is accepted
// meanwhile, and a second result waits in the block until the register frees
// up. node_count is to be written by cfg_we_i only while idle; the block does
// not enforce it. Reset clears the sum, node and dimension positions, the
// flag and the output valid, and sets node_count to 1. No clearing pass is
// needed.
module gcn_post_norm_mean_pool #(
  parameter int unsigned MAX_NODES    = 1024,
  parameter int unsigned FEATURE_DIMS = 128,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gpnmp_pkg::COUNT_W-1:0]       cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // message_value, node_feature, degree, root_weight, norm_mean,
  // norm_sqrt_var, norm_scale, norm_shift, zero pad
  input  logic [gpnmp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // mean_value
  output logic [gpnmp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // dim_index, div_zero
  output logic [gpnmp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned W     = gpnmp_pkg::WORD_W;
  localparam int unsigned CW    = gpnmp_pkg::COUNT_W;
  localparam int unsigned DW    = W + FRAC_BITS;
  localparam int unsigned DIM_W = (FEATURE_DIMS > 1) ? $clog2(FEATURE_DIMS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEG,
    ST_VAR,
    ST_MUL,
    ST_ACC,
    ST_MEAN,
    ST_OUT
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        node_count_q;
  logic [CW-1:0]        np_q;
  logic [DIM_W-1:0]     dim_q;
  logic                 zdiv_q;
  logic                 div_start_q;
  logic                 mul_start_q;
  logic                 m_valid_q;

  logic [W-1:0]         msg_q, feat_q, root_q, nmean_q, sv_q, scale_q, shift_q;
  logic [gpnmp_pkg::DEGREE_W-1:0] deg_q;
  logic [W-1:0]         diff_q;
  logic [W-1:0]         q_q;
  logic [W-1:0]         sum_q;
  logic [W-1:0]         mean_q;
  logic                 dz_q;
  logic [W-1:0]         out_data_q;
  logic [gpnmp_pkg::DIMIDX_W-1:0] out_dim_q;
  logic                 out_last_q;
  logic                 out_dz_q;

  gpnmp_pkg::div_req_t  div_req;
  logic [DW-1:0]        div_dividend;
  logic [W-1:0]         div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic                 mul_done;
  logic [2*W-1:0]       mul_prod;

  logic [W-1:0]         pre;
  logic [W-2:0]         relu;
  logic [W-1:0]         x_val;
  logic [W-1:0]         diff_mag;
  logic [W-1:0]         sv_mag;
  logic                 var_neg;
  logic [W-1:0]         sum_mag;
  logic [CW-1:0]        count;
  logic [W-1:0]         y_val;
  logic [W-1:0]         sum_next;
  logic                 more_nodes;
  logic                 sv_zero;
  logic                 out_free;

  assign pre      = feat_q + root_q;
  assign relu     = pre[W-1] ? '0 : pre[W-2:0];
  assign x_val    = msg_q + div_quo[W-1:0];
  assign diff_mag = diff_q[W-1] ? (~diff_q + W'(1)) : diff_q;
  assign sv_mag   = sv_q[W-1] ? (~sv_q + W'(1)) : sv_q;
  assign var_neg  = diff_q[W-1] ^ sv_q[W-1];
  assign sum_mag  = sum_q[W-1] ? (~sum_q + W'(1)) : sum_q;
  assign sv_zero  = (sv_q == '0);
  assign count    = ({21'b0, node_count_q} > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                               : node_count_q;
  assign y_val    = mul_prod[FRAC_BITS+W-1:FRAC_BITS] + shift_q;
  assign sum_next = sum_q + y_val;
  assign more_nodes = ({1'b0, np_q} + (CW+1)'(1)) < {1'b0, count};
  assign out_free = ~m_valid_q | m_axis_tready;

  always_comb begin
    div_req.start = div_start_q;
    case (state_q)
      ST_DEG: begin
        div_req.steps = gpnmp_pkg::STEP_W'(W - 1);
        div_dividend  = DW'(relu) << (DW - (W - 1));
        div_divisor   = W'({1'b0, deg_q} + (gpnmp_pkg::DEGREE_W+1)'(1));
      end
      ST_VAR: begin
        div_req.steps = gpnmp_pkg::STEP_W'(DW);
        div_dividend  = DW'(diff_mag) << FRAC_BITS;
        div_divisor   = sv_mag;
      end
      default: begin
        div_req.steps = gpnmp_pkg::STEP_W'(W);
        div_dividend  = DW'(sum_mag) << (DW - W);
        div_divisor   = W'(count);
      end
    endcase
  end

  gpnmp_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  gpnmp_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start_q),
    .a_i       (q_q),
    .b_i       (scale_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= CW'(1);
      np_q         <= '0;
      dim_q        <= '0;
      zdiv_q       <= 1'b0;
      div_start_q  <= 1'b0;
      mul_start_q  <= 1'b0;
      m_valid_q    <= 1'b0;
      sum_q        <= '0;
    end else begin
      div_start_q <= 1'b0;
      mul_start_q <= 1'b0;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            div_start_q <= 1'b1;
            state_q     <= ST_DEG;
          end
        end
        ST_DEG: begin
          if (div_done) begin
            if (sv_zero) begin
              zdiv_q      <= 1'b1;
              mul_start_q <= 1'b1;
              state_q     <= ST_MUL;
            end else begin
              div_start_q <= 1'b1;
              state_q     <= ST_VAR;
            end
          end
        end
        ST_VAR: begin
          if (div_done) begin
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            sum_q   <= sum_next;
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (more_nodes) begin
            np_q    <= np_q + CW'(1);
            state_q <= ST_IDLE;
          end else if (count == '0) begin
            state_q <= ST_OUT;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            np_q      <= '0;
            zdiv_q    <= 1'b0;
            sum_q     <= '0;
            dim_q     <= (dim_q == DIM_W'(FEATURE_DIMS - 1)) ? '0 : dim_q + DIM_W'(1);
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          msg_q   <= s_axis_tdata[gpnmp_pkg::OFS_MESSAGE +: W];
          feat_q  <= s_axis_tdata[gpnmp_pkg::OFS_FEATURE +: W];
          deg_q   <= s_axis_tdata[gpnmp_pkg::OFS_DEGREE  +: gpnmp_pkg::DEGREE_W];
          root_q  <= s_axis_tdata[gpnmp_pkg::OFS_ROOT    +: W];
          nmean_q <= s_axis_tdata[gpnmp_pkg::OFS_MEAN    +: W];
          sv_q    <= s_axis_tdata[gpnmp_pkg::OFS_SQRTVAR +: W];
          scale_q <= s_axis_tdata[gpnmp_pkg::OFS_SCALE   +: W];
          shift_q <= s_axis_tdata[gpnmp_pkg::OFS_SHIFT   +: W];
        end
      end
      ST_DEG: begin
        if (div_done) begin
          diff_q <= x_val - nmean_q;
          q_q    <= '0;
        end
      end
      ST_VAR: begin
        if (div_done) begin
          q_q <= var_neg ? (~div_quo[W-1:0] + W'(1)) : div_quo[W-1:0];
        end
      end
      ST_ACC: begin
        mean_q <= '0;
        dz_q   <= zdiv_q | (count == '0);
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_q <= sum_q[W-1] ? (~div_quo[W-1:0] + W'(1)) : div_quo[W-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_q <= mean_q;
          out_dim_q  <= gpnmp_pkg::DIMIDX_W'(dim_q);
          out_last_q <= (dim_q == DIM_W'(FEATURE_DIMS - 1));
          out_dz_q   <= dz_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_dz_q, out_dim_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for gcn_post_norm_mean_pool: a directed table, then
// random dimension-major node streams, checked against an in-bench pooling model.
// Depends on gpnmp_pkg and the block's RTL only.
module tb_top;

  localparam int unsigned WORD_W      = gpnmp_pkg::WORD_W;
  localparam int unsigned DEGREE_W    = gpnmp_pkg::DEGREE_W;
  localparam int unsigned COUNT_W     = gpnmp_pkg::COUNT_W;
  localparam int unsigned DIMIDX_W    = gpnmp_pkg::DIMIDX_W;
  localparam int unsigned IN_TDATA_W  = gpnmp_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = gpnmp_pkg::OUT_TDATA_W;
  localparam int unsigned OUT_TUSER_W = gpnmp_pkg::OUT_TUSER_W;
  localparam int unsigned OFS_MESSAGE = gpnmp_pkg::OFS_MESSAGE;
  localparam int unsigned OFS_FEATURE = gpnmp_pkg::OFS_FEATURE;
  localparam int unsigned OFS_DEGREE  = gpnmp_pkg::OFS_DEGREE;
  localparam int unsigned OFS_ROOT    = gpnmp_pkg::OFS_ROOT;
  localparam int unsigned OFS_MEAN    = gpnmp_pkg::OFS_MEAN;
  localparam int unsigned OFS_SQRTVAR = gpnmp_pkg::OFS_SQRTVAR;
  localparam int unsigned OFS_SCALE   = gpnmp_pkg::OFS_SCALE;
  localparam int unsigned OFS_SHIFT   = gpnmp_pkg::OFS_SHIFT;

  localparam int unsigned MAX_NODES    = 1024;
  localparam int unsigned FEATURE_DIMS = 128;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned COUNT_MAX    = 2047;
  localparam int ITEM_TARGET   = 1750;
  localparam int CALM_TAIL     = 250;
  localparam int SETTLE_CYCLES = 200;
  localparam int QUIET_LIMIT   = 3000;
  localparam int N_ROWS        = 18;

  typedef struct packed {
    bit [WORD_W-1:0]   message_value;
    bit [WORD_W-1:0]   node_feature;
    bit [DEGREE_W-1:0] degree;
    bit [WORD_W-1:0]   root_weight;
    bit [WORD_W-1:0]   norm_mean;
    bit [WORD_W-1:0]   norm_sqrt_var;
    bit [WORD_W-1:0]   norm_scale;
    bit [WORD_W-1:0]   norm_shift;
  } node_item_t;

  typedef struct packed {
    bit [WORD_W-1:0]   mean_value;
    bit [DIMIDX_W-1:0] dim_index;
    bit                last_dim;
    bit                div_zero;
  } pool_result_t;

  typedef struct packed {
    int           set_count;
    node_item_t   item;
    bit           typed;
    pool_result_t want;
  } dir_row_t;

  localparam pool_result_t NO_WANT = '0;

  localparam node_item_t ZERO_NODE = '{32'h0, 32'h0, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
  localparam node_item_t TOP_SHIFT =
    '{32'h0, 32'h0, 10'd0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF};
  localparam node_item_t BOT_SHIFT =
    '{32'h0, 32'h0, 10'd0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h8000_0000};
  localparam node_item_t RELU_WRAP = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0, 32'h0000_0001,
    32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h0};
  localparam node_item_t DEG_TOP = '{32'h0, 32'h4000_0000, 10'd1023, 32'h3FFF_FFFF,
    32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678};
  localparam node_item_t SV_MIN = '{32'h8000_0000, 32'h0001_0000, 10'd0, 32'h0,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
  localparam node_item_t ALL_ONES = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};
  localparam node_item_t PLAIN = '{32'h0001_8000, 32'h0003_0000, 10'd3, 32'h0001_0000,
    32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'h0000_1000};
  localparam node_item_t PLAIN_SV0 = '{32'hFFFE_0000, 32'h0002_4000, 10'd2, 32'h0000_C000,
    32'h0001_0000, 32'h0, 32'h0003_0000, 32'hFFFF_8000};

  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{-1, ZERO_NODE, 1'b1, '{32'h0, 7'd0, 1'b0, 1'b1}},
    '{-1, TOP_SHIFT, 1'b1, '{32'h7FFF_FFFF, 7'd1, 1'b0, 1'b0}},
    '{-1, BOT_SHIFT, 1'b1, '{32'h8000_0000, 7'd2, 1'b0, 1'b0}},
    '{-1, RELU_WRAP, 1'b0, NO_WANT},
    '{-1, DEG_TOP,   1'b0, NO_WANT},
    '{-1, SV_MIN,    1'b0, NO_WANT},
    '{-1, ALL_ONES,  1'b0, NO_WANT},
    '{-1, PLAIN,     1'b0, NO_WANT},
    '{0,  PLAIN,     1'b1, '{32'h0, 7'd8, 1'b0, 1'b1}},
    '{-1, RELU_WRAP, 1'b1, '{32'h0, 7'd9, 1'b0, 1'b1}},
    '{3,  PLAIN,     1'b0, NO_WANT},
    '{-1, DEG_TOP,   1'b0, NO_WANT},
    '{2,  PLAIN,     1'b0, NO_WANT},
    '{int'(COUNT_MAX), PLAIN, 1'b0, NO_WANT},
    '{-1, PLAIN_SV0, 1'b0, NO_WANT},
    '{1,  PLAIN,     1'b0, NO_WANT},
    '{int'(MAX_NODES), ALL_ONES, 1'b0, NO_WANT},
    '{1,  SV_MIN,    1'b0, NO_WANT}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [COUNT_W-1:0]     cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  // pooling model state
  int unsigned  count_reg;
  bit [31:0]    pool_sum;
  int unsigned  node_pos;
  int unsigned  dim_pos;
  bit           zdiv_seen;

  pool_result_t pending_means [$];
  node_item_t   shared_fields;
  bit           idle_en;
  int           sink_hold;
  int           quiet_cycles;
  int           mismatches;
  int           items_sent;
  int           table_items;
  int           means_checked;
  int           dim_wraps;
  int           settings_used;

  gcn_post_norm_mean_pool #(
    .MAX_NODES   (MAX_NODES),
    .FEATURE_DIMS(FEATURE_DIMS),
    .FRAC_BITS   (FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_node(input node_item_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[OFS_MESSAGE +: WORD_W]   = it.message_value;
    d[OFS_FEATURE +: WORD_W]   = it.node_feature;
    d[OFS_DEGREE  +: DEGREE_W] = it.degree;
    d[OFS_ROOT    +: WORD_W]   = it.root_weight;
    d[OFS_MEAN    +: WORD_W]   = it.norm_mean;
    d[OFS_SQRTVAR +: WORD_W]   = it.norm_sqrt_var;
    d[OFS_SCALE   +: WORD_W]   = it.norm_scale;
    d[OFS_SHIFT   +: WORD_W]   = it.norm_shift;
    return d;
  endfunction

  // advance the pooling state by one node; return 1 when a dimension closes
  function automatic bit pool_node(input node_item_t it, output pool_result_t res);
    int unsigned lim;
    bit [31:0]   pre;
    bit [31:0]   relu;
    bit [31:0]   xval;
    bit [31:0]   wdiff;
    bit [31:0]   quo;
    longint      diff;
    longint      sv;
    longint      q;
    longint      prod;
    lim   = (count_reg > MAX_NODES) ? MAX_NODES : count_reg;
    pre   = it.node_feature + it.root_weight;
    relu  = pre[31] ? 32'd0 : pre;
    xval  = it.message_value + relu / (32'(it.degree) + 32'd1);
    wdiff = xval - it.norm_mean;
    diff  = longint'($signed(wdiff));
    sv    = longint'($signed(it.norm_sqrt_var));
    q     = 0;
    if (sv == 0) begin
      zdiv_seen = 1'b1;
    end else begin
      quo = 32'((diff <<< FRAC_BITS) / sv);
      q   = longint'($signed(quo));
    end
    prod     = (q * longint'($signed(it.norm_scale))) >>> FRAC_BITS;
    pool_sum = pool_sum + 32'(prod) + it.norm_shift;
    res = '0;
    if (node_pos + 1 < lim) begin
      node_pos++;
      return 1'b0;
    end
    res.div_zero   = zdiv_seen || (lim == 0);
    res.mean_value = (lim == 0) ? 32'd0 :
                     32'(longint'($signed(pool_sum)) / longint'(lim));
    res.dim_index  = dim_pos[DIMIDX_W-1:0];
    res.last_dim   = (dim_pos == FEATURE_DIMS - 1);
    pool_sum  = '0;
    node_pos  = 0;
    zdiv_seen = 1'b0;
    dim_pos   = (dim_pos >= FEATURE_DIMS - 1) ? 0 : dim_pos + 1;
    return 1'b1;
  endfunction

  function automatic bit [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h0;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3, 4: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  // per-dimension parameters hold across a dimension, with some noise
  function automatic node_item_t make_node();
    node_item_t it;
    if (node_pos == 0 || $urandom_range(0, 7) == 0) begin
      shared_fields.root_weight   = rand_word();
      shared_fields.norm_mean     = rand_word();
      shared_fields.norm_sqrt_var = ($urandom_range(0, 11) == 0) ? 32'h0 : rand_word();
      shared_fields.norm_scale    = rand_word();
      shared_fields.norm_shift    = rand_word();
    end
    it = shared_fields;
    it.message_value = rand_word();
    it.node_feature  = rand_word();
    if ($urandom_range(0, 7) == 0)
      it.degree = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    else
      it.degree = 10'($urandom_range(0, 1023));
    return it;
  endfunction

  task automatic send_node(input node_item_t it, input bit typed, input pool_result_t want);
    pool_result_t model_res;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pack_node(it);
    do @(posedge clk_i); while (!s_axis_tready);
    if (pool_node(it, model_res))
      pending_means.push_back(typed ? want : model_res);
    items_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender until every mean is out and the block has gone quiet
  task automatic settle_block();
    s_axis_tvalid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_node_count(input int unsigned value);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = COUNT_W'(value);
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    count_reg = value;
    settings_used++;
  endtask

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready = 1'b0;
      sink_hold--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready = 1'b0;
      sink_hold = $urandom_range(1, 10) - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected mean transaction: data %h, user %h", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (m_axis_tdata !== want.mean_value) begin
          $error("mean_value: expected %h, got %h", want.mean_value, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[DIMIDX_W-1:0] !== want.dim_index) begin
          $error("dim_index: expected %0d, got %0d", want.dim_index,
                 m_axis_tuser[DIMIDX_W-1:0]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last_dim) begin
          $error("last_dim: expected %b, got %b", want.last_dim, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser[DIMIDX_W] !== want.div_zero) begin
          $error("div_zero: expected %b, got %b", want.div_zero, m_axis_tuser[DIMIDX_W]);
          mismatches++;
        end
        means_checked++;
        if (want.last_dim) dim_wraps++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no transaction for %0d cycles, %0d means outstanding",
               QUIET_LIMIT, pending_means.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned cnt;
    int          n_nodes;
    int          phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sink_hold     = 0;
    idle_en       = 1'b1;
    quiet_cycles  = 0;
    mismatches    = 0;
    items_sent    = 0;
    table_items   = 0;
    means_checked = 0;
    dim_wraps     = 0;
    settings_used = 0;
    count_reg     = 1;
    pool_sum      = '0;
    node_pos      = 0;
    dim_pos       = 0;
    zdiv_seen     = 1'b0;
    shared_fields = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      if (DIR_ROWS[r].set_count >= 0) begin
        settle_block();
        write_node_count(DIR_ROWS[r].set_count);
      end
      send_node(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
      table_items++;
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_block();
      if (phase == 2) begin
        cnt     = COUNT_MAX;
        n_nodes = MAX_NODES;
      end else begin
        case ($urandom_range(0, 9))
          0:       cnt = 0;
          1, 2:    cnt = 1;
          3, 4, 5: cnt = $urandom_range(2, 4);
          6, 7:    cnt = $urandom_range(5, 12);
          default: cnt = $urandom_range(2, 6);
        endcase
        n_nodes = $urandom_range(10, 50);
      end
      write_node_count(cnt);
      idle_en = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      repeat (n_nodes) send_node(make_node(), 1'b0, NO_WANT);
      phase++;
    end
    settle_block();

    $display("Sent %0d node transactions (%0d from the directed table) under %0d counts.",
             items_sent, table_items, settings_used);
    $display("Checked %0d pooled means; the dimension index wrapped %0d times.",
             means_checked, dim_wraps);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
